// ===== design/scs_pkg.sv =====
package scs_pkg;

  localparam int MaxContainers  = 1024;
  localparam int MaxInherited   = 1024;
  localparam int ContainerBytes = 4194304;
  localparam int MetaBytes      = 4096;
  localparam int IdxW           = $clog2(MaxContainers);
  localparam int CntW           = IdxW + 1;
  localparam int InhIdxW        = $clog2(MaxInherited);
  localparam int InhCntW        = InhIdxW + 1;
  localparam int PayloadI       = ContainerBytes - MetaBytes;
  localparam logic PayloadPos   = (ContainerBytes > MetaBytes);
  localparam logic [26:0] Payload = PayloadPos ? 27'(PayloadI) : 27'd0;
  localparam logic [16:0] FullRatio = 17'd65536;

  typedef enum logic [2:0] {
    REQ_UPDATE  = 3'd0,
    REQ_CHECK   = 3'd1,
    REQ_INHERIT = 3'd2,
    REQ_FINISH  = 3'd3,
    REQ_READ    = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] container_id;
    logic [23:0] byte_count;
    logic        is_duplicate;
    logic        is_file_start;
    logic        is_file_end;
    logic [9:0]  entry_index;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        sparse_mark;
    logic [31:0] entry_id;
    logic [31:0] entry_bytes;
    logic        last_entry;
    logic [10:0] container_total;
    logic [10:0] sparse_total;
    logic [10:0] inherited_hits;
    logic [10:0] selected_count;
  } result_t;

  typedef enum logic [4:0] {
    OP_NONE   = 5'd0,
    OP_LOAD   = 5'd1,
    OP_UPDATE = 5'd2,
    OP_CHECK  = 5'd3,
    OP_INHERIT= 5'd4,
    OP_FINISH = 5'd5,
    OP_READ   = 5'd6
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic done;
  } sts_t;

endpackage

// ===== design/scs_ram.sv =====
module scs_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/scs_ctrl.sv =====
module scs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [2:0]         req_type,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic               take,
  output scs_pkg::cmd_t      cmd,
  input  scs_pkg::sts_t      sts
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WORK = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  scs_pkg::op_t op_r, op_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign take       = in_tvalid && in_tready;
  assign cmd.op     = (state_r == S_WORK) ? op_r : scs_pkg::OP_NONE;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          state_nxt = S_WORK;
          unique case (req_type)
            scs_pkg::REQ_UPDATE:  op_nxt = scs_pkg::OP_UPDATE;
            scs_pkg::REQ_CHECK:   op_nxt = scs_pkg::OP_CHECK;
            scs_pkg::REQ_INHERIT: op_nxt = scs_pkg::OP_INHERIT;
            scs_pkg::REQ_FINISH:  op_nxt = scs_pkg::OP_FINISH;
            scs_pkg::REQ_READ:    op_nxt = scs_pkg::OP_READ;
            default:              op_nxt = scs_pkg::OP_LOAD;
          endcase
        end
      end
      S_WORK: begin
        if (sts.done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= scs_pkg::OP_NONE;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end
endmodule

// ===== design/scs_dp.sv =====
module scs_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  scs_pkg::item_t    item,
  input  logic [16:0]       util_threshold,
  input  logic [16:0]       rewrite_limit,
  input  scs_pkg::cmd_t     cmd,
  output scs_pkg::sts_t     sts,
  output scs_pkg::result_t  res
);
  localparam int IW = scs_pkg::IdxW;
  localparam int CW = scs_pkg::CntW;
  localparam int HW = scs_pkg::InhIdxW;
  localparam int HC = scs_pkg::InhCntW;

  typedef enum logic [3:0] {
    P_SCAN   = 4'd0,
    P_WAIT   = 4'd1,
    P_EVAL   = 4'd2,
    P_INSRD  = 4'd3,
    P_INSWT  = 4'd4,
    P_INSCMP = 4'd5,
    P_INHS   = 4'd6,
    P_INHW   = 4'd7,
    P_TRIMRD = 4'd8,
    P_TRIMWT = 4'd9,
    P_TRIM   = 4'd10,
    P_RDWT   = 4'd11,
    P_RDGET  = 4'd12,
    P_RDWT2  = 4'd13,
    P_END    = 4'd14
  } phase_t;

  scs_pkg::item_t item_r;
  phase_t ph_r, ph_nxt;
  logic [CW-1:0] ucnt_r, ucnt_nxt;
  logic [HC-1:0] hcnt_r, hcnt_nxt;
  logic [CW-1:0] slen_r, slen_nxt;
  logic [CW-1:0] spc_r, spc_nxt;
  logic [CW-1:0] ihc_r, ihc_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [HC-1:0] h_r, h_nxt;
  logic [31:0] cur_id_r, cur_id_nxt;
  logic [31:0] cur_b_r, cur_b_nxt;
  logic [IW-1:0] mv_r, mv_nxt;
  logic [47:0] tot_r, tot_nxt;
  logic [47:0] spb_r, spb_nxt;
  logic found_r, found_nxt;
  logic [47:0] prod_r, prod_nxt;
  logic [1:0] st_r, st_nxt;
  logic mark_r, mark_nxt;
  logic done_r, done_nxt;
  logic [31:0] eid_r, eid_nxt;
  logic [31:0] eb_r, eb_nxt;
  logic last_r, last_nxt;

  logic          uid_we, ub_we, inh_we, so_we;
  logic [IW-1:0] uid_wa, ub_wa, so_wa, u_ra, so_ra;
  logic [HW-1:0] inh_wa, inh_ra;
  logic [31:0]   uid_wd, ub_wd, inh_wd;
  logic [IW-1:0] so_wd;
  logic [31:0]   uid_rd, ub_rd, inh_rd;
  logic [IW-1:0] so_rd;
  logic [32:0]   sum;

  scs_ram #(.Width(32), .Depth(scs_pkg::MaxContainers)) u_uid (
    .clk, .we(uid_we), .waddr(uid_wa), .wdata(uid_wd), .raddr(u_ra), .rdata(uid_rd));
  scs_ram #(.Width(32), .Depth(scs_pkg::MaxContainers)) u_ub (
    .clk, .we(ub_we), .waddr(ub_wa), .wdata(ub_wd), .raddr(u_ra), .rdata(ub_rd));
  scs_ram #(.Width(32), .Depth(scs_pkg::MaxInherited)) u_inh (
    .clk, .we(inh_we), .waddr(inh_wa), .wdata(inh_wd), .raddr(inh_ra), .rdata(inh_rd));
  scs_ram #(.Width(IW), .Depth(scs_pkg::MaxContainers)) u_so (
    .clk, .we(so_we), .waddr(so_wa), .wdata(so_wd), .raddr(so_ra), .rdata(so_rd));

  assign sum = {1'b0, ub_rd} + 33'(item_r.byte_count);
  assign sts.done = done_r;
  assign res.status = st_r;
  assign res.sparse_mark = mark_r;
  assign res.entry_id = eid_r;
  assign res.entry_bytes = eb_r;
  assign res.last_entry = last_r;
  assign res.container_total = 11'(ucnt_r);
  assign res.sparse_total = 11'(spc_r);
  assign res.inherited_hits = 11'(ihc_r);
  assign res.selected_count = 11'(slen_r);

  always_comb begin
    ph_nxt = ph_r; ucnt_nxt = ucnt_r; hcnt_nxt = hcnt_r; slen_nxt = slen_r;
    spc_nxt = spc_r; ihc_nxt = ihc_r; i_nxt = i_r; j_nxt = j_r; h_nxt = h_r;
    cur_id_nxt = cur_id_r; cur_b_nxt = cur_b_r; mv_nxt = mv_r; tot_nxt = tot_r;
    spb_nxt = spb_r; found_nxt = found_r; prod_nxt = prod_r; st_nxt = st_r;
    mark_nxt = mark_r; done_nxt = 1'b0; eid_nxt = eid_r; eb_nxt = eb_r;
    last_nxt = last_r;
    uid_we = 1'b0; ub_we = 1'b0; inh_we = 1'b0; so_we = 1'b0;
    uid_wa = i_r[IW-1:0]; ub_wa = i_r[IW-1:0]; so_wa = j_r[IW-1:0];
    inh_wa = hcnt_r[HW-1:0];
    uid_wd = item_r.container_id; ub_wd = 32'(item_r.byte_count);
    inh_wd = item_r.container_id; so_wd = mv_r;
    u_ra = i_r[IW-1:0]; so_ra = j_r[IW-1:0]; inh_ra = h_r[HW-1:0];

    if (cmd.op == scs_pkg::OP_NONE) begin
      ph_nxt = P_SCAN; i_nxt = '0; h_nxt = '0; found_nxt = 1'b0;
      tot_nxt = '0; spb_nxt = '0;
      if (take) begin
        st_nxt = scs_pkg::ST_OK; mark_nxt = 1'b0; eid_nxt = '0; eb_nxt = '0;
        last_nxt = 1'b0;
        u_ra = '0; inh_ra = '0;
      end
    end else if (!done_r) begin
      unique case (cmd.op)
        scs_pkg::OP_UPDATE: begin
          // Linear search of the usage table.
          priority case (ph_r)
            P_SCAN: begin
              if (i_r >= ucnt_r) begin
                if (ucnt_r >= CW'(scs_pkg::MaxContainers)) begin
                  st_nxt = scs_pkg::ST_FULL;
                end else begin
                  uid_we = 1'b1; ub_we = 1'b1;
                  ucnt_nxt = ucnt_r + 1'b1;
                end
                done_nxt = 1'b1; ph_nxt = P_END;
              end else begin
                ph_nxt = P_WAIT;
              end
            end
            P_WAIT: ph_nxt = P_EVAL;
            P_EVAL: begin
              if (uid_rd == item_r.container_id) begin
                ub_we = 1'b1;
                ub_wd = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                done_nxt = 1'b1; ph_nxt = P_END;
              end else begin
                i_nxt = i_r + 1'b1; ph_nxt = P_SCAN;
              end
            end
            default: ;
          endcase
        end
        scs_pkg::OP_CHECK, scs_pkg::OP_INHERIT: begin
          priority case (ph_r)
            P_SCAN: begin
              if (h_r >= hcnt_r) begin
                if (cmd.op == scs_pkg::OP_CHECK) begin
                  mark_nxt = 1'b0;
                end else if (hcnt_r >= HC'(scs_pkg::MaxInherited)) begin
                  st_nxt = scs_pkg::ST_FULL;
                end else begin
                  inh_we = 1'b1; hcnt_nxt = hcnt_r + 1'b1;
                end
                done_nxt = 1'b1; ph_nxt = P_END;
              end else begin
                ph_nxt = P_WAIT;
              end
            end
            P_WAIT: ph_nxt = P_EVAL;
            P_EVAL: begin
              if (inh_rd == item_r.container_id) begin
                mark_nxt = (cmd.op == scs_pkg::OP_CHECK) && item_r.is_duplicate &&
                           !item_r.is_file_start && !item_r.is_file_end;
                done_nxt = 1'b1; ph_nxt = P_END;
              end else begin
                h_nxt = h_r + 1'b1; ph_nxt = P_SCAN;
              end
            end
            default: ;
          endcase
        end
        scs_pkg::OP_FINISH: begin
          priority case (ph_r)
            P_SCAN: begin
              if (i_r == '0) begin
                slen_nxt = '0; spc_nxt = '0; ihc_nxt = '0;
              end
              if (i_r >= ucnt_r) begin
                j_nxt = slen_nxt - 1'b1;
                ph_nxt = P_TRIMRD;
              end else begin
                ph_nxt = P_WAIT;
              end
            end
            P_WAIT: ph_nxt = P_EVAL;
            P_EVAL: begin
              cur_id_nxt = uid_rd; cur_b_nxt = ub_rd;
              tot_nxt = tot_r + 48'(ub_rd);
              prod_nxt = 48'(util_threshold) * 48'(scs_pkg::Payload);
              ph_nxt = P_INSRD;
            end
            P_INSRD: begin
              if (!scs_pkg::PayloadPos || {cur_b_r, 16'd0} >= prod_r) begin
                i_nxt = i_r + 1'b1; ph_nxt = P_SCAN;
              end else begin
                h_nxt = '0; found_nxt = 1'b0; ph_nxt = P_INHS;
              end
            end
            P_INHS: begin
              if (found_r || h_r >= hcnt_r) begin
                if (found_r) ihc_nxt = ihc_r + 1'b1;
                spc_nxt = spc_r + 1'b1;
                spb_nxt = spb_r + 48'(cur_b_r);
                j_nxt = slen_r; ph_nxt = P_INSWT;
              end else begin
                ph_nxt = P_INHW;
              end
            end
            P_INHW: begin
              ph_nxt = P_INSCMP;
            end
            P_INSCMP: begin
              if (inh_rd == cur_id_r) found_nxt = 1'b1;
              h_nxt = h_r + 1'b1; ph_nxt = P_INHS;
            end
            P_INSWT: begin
              // Insertion: read slot j-1, its bytes, shift if larger.
              if (j_r == '0) begin
                so_we = 1'b1; so_wd = i_r[IW-1:0];
                slen_nxt = slen_r + 1'b1;
                i_nxt = i_r + 1'b1; ph_nxt = P_SCAN;
              end else begin
                so_ra = IW'(j_r - 1'b1);
                ph_nxt = P_RDWT;
              end
            end
            P_RDWT: begin
              mv_nxt = so_rd; u_ra = so_rd; ph_nxt = P_RDGET;
            end
            P_RDGET: begin
              u_ra = mv_r; ph_nxt = P_RDWT2;
            end
            P_RDWT2: begin
              if (ub_rd > cur_b_r) begin
                so_we = 1'b1; so_wd = mv_r;
                j_nxt = j_r - 1'b1; ph_nxt = P_INSWT;
              end else begin
                so_we = 1'b1; so_wd = i_r[IW-1:0];
                slen_nxt = slen_r + 1'b1;
                i_nxt = i_r + 1'b1; ph_nxt = P_SCAN;
              end
            end
            P_TRIMRD: begin
              prod_nxt = 48'(rewrite_limit) * tot_r[31:0];
              ph_nxt = P_TRIMWT;
            end
            P_TRIMWT: begin
              if (rewrite_limit >= scs_pkg::FullRatio || slen_r == '0 ||
                  {spb_r, 16'd0} <= {16'd0, prod_r} +
                  {32'(tot_r[47:32]) * 32'(rewrite_limit), 32'd0}) begin
                done_nxt = 1'b1; ph_nxt = P_END;
              end else begin
                so_ra = IW'(slen_r - 1'b1);
                ph_nxt = P_TRIM;
              end
            end
            P_TRIM: begin
              u_ra = so_rd; ph_nxt = P_END;
            end
            P_END: begin
              spb_nxt = spb_r - 48'(ub_rd);
              slen_nxt = slen_r - 1'b1;
              ph_nxt = P_TRIMRD;
            end
            default: ;
          endcase
        end
        scs_pkg::OP_READ: begin
          priority case (ph_r)
            P_SCAN: begin
              if (CW'(item_r.entry_index) >= slen_r) begin
                st_nxt = scs_pkg::ST_RANGE; done_nxt = 1'b1; ph_nxt = P_END;
              end else begin
                so_ra = item_r.entry_index; ph_nxt = P_WAIT;
              end
            end
            P_WAIT: begin
              u_ra = so_rd; ph_nxt = P_EVAL;
            end
            P_EVAL: begin
              eid_nxt = uid_rd; eb_nxt = ub_rd;
              last_nxt = (CW'(item_r.entry_index) + 1'b1 == slen_r);
              done_nxt = 1'b1; ph_nxt = P_END;
            end
            default: ;
          endcase
        end
        default: begin
          done_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) item_r <= item;
    ph_r <= ph_nxt; i_r <= i_nxt; j_r <= j_nxt; h_r <= h_nxt;
    cur_id_r <= cur_id_nxt; cur_b_r <= cur_b_nxt; mv_r <= mv_nxt;
    tot_r <= tot_nxt; spb_r <= spb_nxt; found_r <= found_nxt; prod_r <= prod_nxt;
    st_r <= st_nxt; mark_r <= mark_nxt; eid_r <= eid_nxt; eb_r <= eb_nxt;
    last_r <= last_nxt;
    if (!rst_n) begin
      ucnt_r <= '0; hcnt_r <= '0; slen_r <= '0; spc_r <= '0; ihc_r <= '0;
      done_r <= 1'b0;
    end else begin
      ucnt_r <= ucnt_nxt; hcnt_r <= hcnt_nxt; slen_r <= slen_nxt;
      spc_r <= spc_nxt; ihc_r <= ihc_nxt; done_r <= done_nxt;
    end
  end
endmodule

// ===== design/sparse_container_selector.sv =====
// One item is taken at a time and answered with exactly one result transfer, which
// is held until it is accepted; the input is ready again in the cycle after that.
// The result is offered once the datapath raises its registered done flag and the
// control moves from its work state to its output state. A usage update or
// inherited-ID load compares the stored entries one by one and appends the ID when
// it is not found; a chunk check compares them the same way, a read looks up one
// sorted entry. A finish scans every container, probes the inherited list for each
// sparse one, inserts it into the sorted list by its bytes, and then trims the
// largest entries from the end of that list; unused request types do no work.
// Configuration writes (index 0 threshold, 1 rewrite limit) belong between items.
module sparse_container_selector (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // req_type[2:0], container_id[34:3], byte_count[58:35], is_duplicate[59],
  // is_file_start[60], is_file_end[61], entry_index[71:62]
  input  logic [71:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[1:0], sparse_mark[2], entry_id[34:3], entry_bytes[66:35],
  // last_entry[67], container_total[78:68], sparse_total[89:79],
  // inherited_hits[100:90], selected_count[111:101]
  output logic [111:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [16:0]  cfg_data
);
  logic [16:0] thr_r, lim_r;
  logic take;
  scs_pkg::item_t item;
  scs_pkg::cmd_t cmd;
  scs_pkg::sts_t sts;
  scs_pkg::result_t res;

  assign cfg_ready = 1'b1;
  assign item.req_type      = in_tdata[2:0];
  assign item.container_id  = in_tdata[34:3];
  assign item.byte_count    = in_tdata[58:35];
  assign item.is_duplicate  = in_tdata[59];
  assign item.is_file_start = in_tdata[60];
  assign item.is_file_end   = in_tdata[61];
  assign item.entry_index   = in_tdata[71:62];
  assign out_tdata = {res.selected_count, res.inherited_hits, res.sparse_total,
                      res.container_total, res.last_entry, res.entry_bytes,
                      res.entry_id, res.sparse_mark, res.status};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 17'd32768;
      lim_r <= scs_pkg::FullRatio;
    end else if (cfg_valid) begin
      if (cfg_index) lim_r <= cfg_data;
      else thr_r <= cfg_data;
    end
  end

  scs_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .req_type(in_tdata[2:0]),
    .out_tvalid, .out_tready, .take, .cmd, .sts);

  scs_dp u_dp (
    .clk, .rst_n, .take, .item, .util_threshold(thr_r), .rewrite_limit(lim_r),
    .cmd, .sts, .res);
endmodule
